// ===== rtl/core/tfb_pkg.sv =====
// ----------------------------------------------------------------------------
// tfb_pkg
// Types, constants and the CRC-16/CCITT-FALSE byte update shared by the
// telemetry frame builder.
// ----------------------------------------------------------------------------
package tfb_pkg;

    localparam logic [7:0]  SYNC_T         = 8'h54;   // 'T'
    localparam logic [7:0]  SYNC_M         = 8'h4D;   // 'M'
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_MSB        = 16'h8000;
    localparam logic [8:0]  FRAME_OVERHEAD = 9'd7;

    localparam logic [7:0]  VERSION_RESET  = 8'd1;
    localparam logic [8:0]  MAX_LEN_RESET  = 9'd255;

    localparam int CFG_DATA_W = 9;
    localparam logic CFG_FRAME_VERSION = 1'b0;
    localparam logic CFG_MAX_FRAME_LEN = 1'b1;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;

    typedef enum logic [1:0] {
        CMD_REJECT,
        CMD_HEADER,
        CMD_DATA
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic       has_data;   // header carries the first payload byte
        logic       is_last;    // close the frame with the CRC after this request
        logic [7:0] data;
        logic [7:0] ptype;
        logic [7:0] plen;
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_T,
        PH_M,
        PH_VER,
        PH_TYPE,
        PH_LEN,
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_REJECT
    } phase_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/tfb_front.sv =====
// ----------------------------------------------------------------------------
// tfb_front
// Accepts payload bytes, tracks frame membership and length, and turns each
// start or in-frame byte into a request for the back end: reject, header or payload.
// ----------------------------------------------------------------------------
module tfb_front
    import tfb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] data_byte,
    input  logic       start_req,
    input  logic [7:0] packet_type,
    input  logic [7:0] payload_len,
    input  logic [8:0] max_frame_len,
    output logic       push,
    output cmd_t       push_cmd
);

    logic       in_frame_reg, in_frame_next;
    logic [7:0] left_reg, left_next;
    logic       too_long;

    assign too_long = ({1'b0, payload_len} + FRAME_OVERHEAD) > max_frame_len;

    always_comb begin
        in_frame_next     = in_frame_reg;
        left_next         = left_reg;
        push              = 1'b0;
        push_cmd.kind     = CMD_DATA;
        push_cmd.has_data = 1'b1;
        push_cmd.is_last  = 1'b0;
        push_cmd.data     = data_byte;
        push_cmd.ptype    = packet_type;
        push_cmd.plen     = payload_len;
        if (in_fire) begin
            if (start_req) begin
                push          = 1'b1;
                in_frame_next = 1'b0;
                left_next     = 8'd0;
                if (too_long) begin
                    push_cmd.kind = CMD_REJECT;
                end else if (payload_len == 8'd0) begin
                    push_cmd.kind     = CMD_HEADER;
                    push_cmd.has_data = 1'b0;
                    push_cmd.is_last  = 1'b1;
                end else begin
                    push_cmd.kind    = CMD_HEADER;
                    push_cmd.is_last = (payload_len == 8'd1);
                    in_frame_next    = (payload_len != 8'd1);
                    left_next        = payload_len - 8'd1;
                end
            end else if (in_frame_reg) begin
                push             = 1'b1;
                push_cmd.is_last = (left_reg == 8'd1);
                in_frame_next    = (left_reg != 8'd1);
                left_next        = left_reg - 8'd1;
            end
            // bytes outside a frame: drop
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            left_reg     <= 8'd0;
        end else begin
            in_frame_reg <= in_frame_next;
            left_reg     <= left_next;
        end
    end

endmodule

// ===== rtl/core/tfb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// tfb_cmd_fifo
// Short request queue between front and back end.
// ----------------------------------------------------------------------------
module tfb_cmd_fifo
    import tfb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output logic head_valid,
    output cmd_t head
);

    cmd_t                 mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_PTR_W:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != CMD_DEPTH[CMD_PTR_W:0]);
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/tfb_back.sv =====
// ----------------------------------------------------------------------------
// tfb_back
// Walks each queued request through its output bytes (header, payload,
// CRC, reject), keeps the running CRC and drives the output register.
// ----------------------------------------------------------------------------
module tfb_back
    import tfb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  cmd_t       head,
    output logic       pop,
    input  logic [7:0] frame_version,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    phase_t      ph_reg, ph_next;
    phase_t      first_ph, cur_ph, succ_ph;
    logic        done;
    logic        slot_free, advance;
    logic [7:0]  byte_sel;
    logic        end_sel, status_sel, feed;
    logic [15:0] crc_reg, crc_next, crc_base;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;
    logic        m_tuser_reg, m_tuser_next;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign advance   = head_valid && slot_free;

    always_comb begin
        case (head.kind)
            CMD_REJECT: first_ph = PH_REJECT;
            CMD_HEADER: first_ph = PH_T;
            CMD_DATA:   first_ph = PH_DATA;
            default:    first_ph = PH_REJECT;
        endcase
        cur_ph = (ph_reg == PH_IDLE) ? first_ph : ph_reg;
    end

    // next state
    always_comb begin
        succ_ph = PH_IDLE;
        done    = 1'b0;
        case (cur_ph)
            PH_T:      succ_ph = PH_M;
            PH_M:      succ_ph = PH_VER;
            PH_VER:    succ_ph = PH_TYPE;
            PH_TYPE:   succ_ph = PH_LEN;
            PH_LEN:    succ_ph = head.has_data ? PH_DATA : PH_CRC_LO;
            PH_DATA: begin
                if (head.is_last) begin
                    succ_ph = PH_CRC_LO;
                end else begin
                    done = 1'b1;
                end
            end
            PH_CRC_LO: succ_ph = PH_CRC_HI;
            default:   done = 1'b1;
        endcase
        ph_next = advance ? (done ? PH_IDLE : succ_ph) : ph_reg;
    end

    // outputs
    always_comb begin
        byte_sel   = 8'h00;
        end_sel    = 1'b0;
        status_sel = 1'b0;
        feed       = 1'b1;
        case (cur_ph)
            PH_T:      byte_sel = SYNC_T;
            PH_M:      byte_sel = SYNC_M;
            PH_VER:    byte_sel = frame_version;
            PH_TYPE:   byte_sel = head.ptype;
            PH_LEN:    byte_sel = head.plen;
            PH_DATA:   byte_sel = head.data;
            PH_CRC_LO: begin
                byte_sel = crc_reg[7:0];
                feed     = 1'b0;
            end
            PH_CRC_HI: begin
                byte_sel = crc_reg[15:8];
                end_sel  = 1'b1;
                feed     = 1'b0;
            end
            default: begin
                end_sel    = 1'b1;
                status_sel = 1'b1;
                feed       = 1'b0;
            end
        endcase
    end

    assign pop      = advance && done;
    // restart the CRC on every header
    assign crc_base = (cur_ph == PH_T) ? CRC_INIT : crc_reg;
    assign crc_next = (advance && feed) ? crc_feed(crc_base, byte_sel) : crc_reg;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (slot_free) begin
            m_tvalid_next = head_valid;
            m_tdata_next  = byte_sel;
            m_tlast_next  = end_sel;
            m_tuser_next  = status_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg       <= PH_IDLE;
            crc_reg      <= CRC_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            ph_reg       <= ph_next;
            crc_reg      <= crc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/core/telemetry_frame_builder_crc16.sv =====
// ----------------------------------------------------------------------------
// telemetry_frame_builder_crc16
// Frames a payload byte stream as 'T','M',version,type,length,payload,CRC16.
//
//   channel | dir | handshake           | content
//   s_      | in  | s_tvalid / s_tready | tdata: data_byte, packet_type,
//           |     |                     |        payload_len; tuser: start_req
//   m_      | out | m_tvalid / m_tready | tdata: frame_byte; tlast: frame_end;
//           |     |                     | tuser: status
//   cfg_    | in  | cfg_we              | 0 frame_version, 1 max_frame_len
//
// Payload bytes flow one per cycle while the request queue has room; a start byte
// with payload yields 6 output bytes (5 header + 1 payload), the last byte 3
// (payload + 2 CRC bytes); the back end's single output register emits one
// per cycle unless stalled. A 4-entry request queue lets input run on while
// output is stalled. Reset is synchronous and empties queue and output register at once.
// ----------------------------------------------------------------------------
module telemetry_frame_builder_crc16
    import tfb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // data_byte, packet_type, payload_len
    input  logic                  s_tuser,   // start_req
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // frame_byte
    output logic                  m_tlast,   // frame_end
    output logic                  m_tuser,   // status
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [7:0] frame_version_reg;
    logic [8:0] max_frame_len_reg;
    logic       in_fire, push, push_ready, pop, head_valid;
    cmd_t       push_cmd, head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_version_reg <= VERSION_RESET;
            max_frame_len_reg <= MAX_LEN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FRAME_VERSION: frame_version_reg <= cfg_wdata[7:0];
                CFG_MAX_FRAME_LEN: max_frame_len_reg <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    assign s_tready = push_ready;
    assign in_fire  = s_tvalid && push_ready;

    tfb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .data_byte     (s_tdata[7:0]),
        .start_req     (s_tuser),
        .packet_type   (s_tdata[15:8]),
        .payload_len   (s_tdata[23:16]),
        .max_frame_len (max_frame_len_reg),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    tfb_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    tfb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .frame_version (frame_version_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser)
    );

endmodule

// ===== rtl/core/tfb_checker.sv =====
// ----------------------------------------------------------------------------
// tfb_checker
// Port-level checks on the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module tfb_checker
    import tfb_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [7:0]            m_tdata,
    input logic                  m_tlast,
    input logic                  m_tuser
);

    // a stalled output holds its byte, end and status
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("output changed while stalled");

    a_reject_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
        else $error("reject result not marked as end with zero byte");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // straight after reset, with nothing accepted the output stage stays empty
    a_no_spurious: assert property (@(posedge aclk)
        !aresetn ##1 !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("output appeared without input");

endmodule

bind telemetry_frame_builder_crc16 tfb_checker u_tfb_checker (.*);

// ===== tb/frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_checker
// Scoreboard for the telemetry frame builder. Watches the request, result and
// register write ports, rebuilds each frame (header, payload, CRC-16) from the
// accepted requests and compares every result byte in order.
// ----------------------------------------------------------------------------
module frame_checker
    import tfb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [23:0]           s_tdata,   // data_byte, packet_type, payload_len
    input  logic                  s_tuser,   // start_req
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,   // frame_byte
    input  logic                  m_tlast,   // frame_end
    input  logic                  m_tuser,   // status
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending_count,
    output int                    frames_closed,
    output int                    rejects_seen,
    output int                    bytes_checked
);

    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       status;
    } frame_out_t;

    frame_out_t  expected_frame_bytes[$];
    frame_out_t  oldest;

    logic [7:0]  version_q;
    logic [8:0]  max_len_q;
    logic [15:0] crc_q;
    logic [7:0]  left_q;
    logic        in_frame_q;

    int errors  = 0;
    int frames  = 0;
    int rejects = 0;
    int checked = 0;

    // MSB-first CRC, one bit per pass: feedback is the top bit xor the data bit
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        crc_q = crc16_step(crc_q, b);
        expected_frame_bytes.push_back(frame_out_t'{b, 1'b0, 1'b0});
    endtask

    task automatic push_crc();
        expected_frame_bytes.push_back(frame_out_t'{crc_q[7:0], 1'b0, 1'b0});
        expected_frame_bytes.push_back(frame_out_t'{crc_q[15:8], 1'b1, 1'b0});
        crc_q      = CRC_INIT;
        left_q     = '0;
        in_frame_q = 1'b0;
    endtask

    task automatic frame_bytes_for_request(input logic [7:0] data, input logic start,
                                           input logic [7:0] ptype, input logic [7:0] plen);
        if (start) begin
            // a new start drops whatever frame was open
            crc_q      = CRC_INIT;
            left_q     = '0;
            in_frame_q = 1'b0;
            if ({1'b0, plen} + FRAME_OVERHEAD > max_len_q) begin
                expected_frame_bytes.push_back(frame_out_t'{8'h00, 1'b1, 1'b1});
                return;
            end
            push_byte(SYNC_T);
            push_byte(SYNC_M);
            push_byte(version_q);
            push_byte(ptype);
            push_byte(plen);
            if (plen == 8'd0) begin
                push_crc();
                return;
            end
            in_frame_q = 1'b1;
            left_q     = plen;
        end else if (!in_frame_q) begin
            return;
        end
        push_byte(data);
        left_q = left_q - 8'd1;
        if (left_q == 8'd0) begin
            push_crc();
        end
    endtask

    task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_frame_bytes.delete();
            version_q  = VERSION_RESET;
            max_len_q  = MAX_LEN_RESET;
            crc_q      = CRC_INIT;
            left_q     = '0;
            in_frame_q = 1'b0;
        end else begin
            // check output first: nothing can come out on the edge its request went in
            if (m_tvalid && m_tready) begin
                if (expected_frame_bytes.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: unexpected result, expected none, actual %02h/%0b/%0b",
                                 $time, m_tdata, m_tlast, m_tuser);
                    end
                end else begin
                    oldest = expected_frame_bytes.pop_front();
                    if (m_tdata !== oldest.frame_byte) begin
                        report("frame_byte", oldest.frame_byte, m_tdata);
                    end
                    if (m_tlast !== oldest.frame_end) begin
                        report("frame_end", {7'd0, oldest.frame_end}, {7'd0, m_tlast});
                    end
                    if (m_tuser !== oldest.status) begin
                        report("status", {7'd0, oldest.status}, {7'd0, m_tuser});
                    end
                    checked++;
                    if (oldest.status) begin
                        rejects++;
                    end else if (oldest.frame_end) begin
                        frames++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_FRAME_VERSION) begin
                    version_q = cfg_wdata[7:0];
                end else begin
                    max_len_q = cfg_wdata;
                end
            end
            if (s_tvalid && s_tready) begin
                frame_bytes_for_request(s_tdata[7:0], s_tuser, s_tdata[15:8], s_tdata[23:16]);
            end
        end
        fail_count    <= errors;
        pending_count <= expected_frame_bytes.size();
        frames_closed <= frames;
        rejects_seen  <= rejects;
        bytes_checked <= checked;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the telemetry frame builder: a directed packet set, then
// random packet sequences over several register settings and flow-control
// patterns, with a long output hold-off; the verdict comes from the checker.
// ----------------------------------------------------------------------------
module tb;
    import tfb_pkg::*;

    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 16;
    localparam int NUM_PHASES    = 5;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;   // data_byte, packet_type, payload_len
    logic                  s_tuser;   // start_req
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // frame_byte
    logic                  m_tlast;   // frame_end
    logic                  m_tuser;   // status
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending_count;
    int frames_closed;
    int rejects_seen;
    int bytes_checked;

    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    bit         hold_off_go   = 1'b0;
    int         hold_left     = 0;
    int         requests_sent = 0;
    int         payload_items = 0;
    logic [8:0] cur_max_len   = MAX_LEN_RESET;

    telemetry_frame_builder_crc16 uut (.*);

    frame_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d frame bytes still expected", pending_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: random stalls, or a counted hold-off when asked
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_off_go) begin
                hold_off_go = 1'b0;
                hold_left   = HOLD_CYCLES;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // valid stays high after a request so back-to-back requests need no drop
    task automatic send_item(input logic [7:0] data, input logic start,
                             input logic [7:0] ptype, input logic [7:0] plen);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {plen, ptype, data};
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        requests_sent++;
    endtask

    task automatic send_packet(input logic [7:0] ptype, input logic [7:0] plen, input int nbytes);
        logic fits;
        fits = ({1'b0, plen} + FRAME_OVERHEAD <= cur_max_len);
        for (int k = 0; k < nbytes; k++) begin
            if (k == 0) begin
                send_item(8'($urandom_range(255)), 1'b1, ptype, plen);
            end else begin
                send_item(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)),
                          8'($urandom_range(255)));
            end
            if (k == 0 || (fits && k < int'(plen))) begin
                payload_items++;
            end
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_MAX_FRAME_LEN) begin
            cur_max_len = val;
        end
    endtask

    task automatic random_packet();
        int         pick;
        int         shape;
        int         nbytes;
        logic [7:0] plen;
        logic       fits;
        pick = $urandom_range(99);
        if (pick < 75) begin
            plen = 8'($urandom_range(1, 12));
        end else if (pick < 87) begin
            plen = 8'($urandom_range(13, 40));
        end else if (pick < 93) begin
            plen = 8'd0;
        end else begin
            plen = 8'($urandom_range(200, 255));
        end
        fits  = ({1'b0, plen} + FRAME_OVERHEAD <= cur_max_len);
        shape = $urandom_range(99);
        if (shape >= 95) begin
            // stray bytes: dropped when idle, else they feed the open frame
            repeat ($urandom_range(1, 3)) begin
                send_item(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)),
                          8'($urandom_range(255)));
            end
            return;
        end
        if (!fits) begin
            nbytes = 1 + $urandom_range(0, 3);
        end else if (plen == 8'd0) begin
            nbytes = (shape < 80) ? 1 : 1 + $urandom_range(1, 2);
        end else if (plen > 8'd40) begin
            nbytes = $urandom_range(1, 6);
        end else if (shape < 78) begin
            nbytes = int'(plen);
        end else if (shape < 88) begin
            nbytes = $urandom_range(1, int'(plen));
        end else begin
            nbytes = int'(plen) + $urandom_range(1, 3);
        end
        send_packet(8'($urandom_range(255)), plen, nbytes);
    endtask

    task automatic run_phase(input int ph);
        int goal;
        case (ph)
            0: begin
                write_reg(CFG_FRAME_VERSION, 9'h000);
                write_reg(CFG_MAX_FRAME_LEN, 9'd8);
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1: begin
                write_reg(CFG_FRAME_VERSION, 9'h0FF);
                write_reg(CFG_MAX_FRAME_LEN, 9'd262);
                send_idle_pct = 47;
                stall_pct     = 0;
            end
            2: begin
                write_reg(CFG_FRAME_VERSION, 9'($urandom_range(255)));
                write_reg(CFG_MAX_FRAME_LEN, 9'd7);
                send_idle_pct = 0;
                stall_pct     = 47;
            end
            3: begin
                write_reg(CFG_FRAME_VERSION, 9'($urandom_range(255)));
                write_reg(CFG_MAX_FRAME_LEN, 9'h1FF);
                send_idle_pct = 14;
                stall_pct     = 14;
            end
            default: begin
                write_reg(CFG_FRAME_VERSION, {1'b0, VERSION_RESET});
                write_reg(CFG_MAX_FRAME_LEN, 9'($urandom_range(8, 60)));
                send_idle_pct = 0;
                stall_pct     = 47;
            end
        endcase
        goal = payload_items + PHASE_ITEMS;
        while (payload_items < goal) begin
            random_packet();
        end
        if (ph == 1) begin
            // hold the output while a full-length packet streams in back to back
            drain_results();
            send_idle_pct = 0;
            hold_off_go   = 1'b1;
            send_packet(8'($urandom_range(255)), 8'd255, 255);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FRAME_VERSION;
        cfg_wdata = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed set on reset register values
        send_item(8'h00, 1'b1, 8'h00, 8'd1);
        send_item(8'hFF, 1'b1, 8'hFF, 8'd0);
        send_item(8'hA5, 1'b0, 8'hFF, 8'hFF);
        send_item(8'h11, 1'b1, 8'h5A, 8'd248);
        send_item(8'h22, 1'b0, 8'h00, 8'h00);
        send_item(8'h33, 1'b1, 8'h01, 8'd249);
        send_item(8'h44, 1'b0, 8'h00, 8'h00);
        send_item(8'h55, 1'b0, 8'hFF, 8'hFF);
        send_item(8'hFF, 1'b1, 8'h80, 8'd255);
        send_item(8'h01, 1'b1, 8'h02, 8'd4);
        send_item(8'h02, 1'b0, 8'h00, 8'h00);
        send_item(8'h03, 1'b1, 8'h03, 8'd2);
        send_item(8'h04, 1'b0, 8'hFF, 8'hFF);
        send_item(8'hFF, 1'b1, 8'h7F, 8'd3);
        send_item(8'h00, 1'b0, 8'h00, 8'h00);
        send_item(8'hFF, 1'b0, 8'hFF, 8'hFF);
        drain_results();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            run_phase(ph);
        end
        drain_results();

        $display("Sent %0d requests: directed set, %0d random phases, one long output hold-off",
                 requests_sent, NUM_PHASES);
        $display("Checked %0d result bytes: %0d closed frames, %0d rejects",
                 bytes_checked, frames_closed, rejects_seen);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tfb_pkg.sv
rtl/core/tfb_front.sv
rtl/core/tfb_cmd_fifo.sv
rtl/core/tfb_back.sv
rtl/core/telemetry_frame_builder_crc16.sv
rtl/core/tfb_checker.sv
tb/frame_checker.sv
tb/tb.sv
